// File: rtl/udpsig_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package udpsig_pkg;

   // Frame geometry limits.
   localparam int MAX_FRAME         = 2048;
   localparam int MAX_CAPTURE_LIMIT = 1500;

   // The position counter saturates at MAX_FRAME, so it must hold that value.
   localparam int POS_W = $clog2(MAX_FRAME + 1);
   // Width of the captured length as it appears on the result channel.
   localparam int CAP_W = 11;

   // Byte offsets inside an Ethernet + IPv4 (20-byte header) + UDP frame.
   localparam int OFS_ETYPE_HI  = 12;
   localparam int OFS_ETYPE_LO  = 13;
   localparam int OFS_IP_PROTO  = 23;
   localparam int OFS_SPORT_HI  = 34;
   localparam int OFS_SPORT_LO  = 35;
   localparam int OFS_ULEN_HI   = 38;
   localparam int OFS_ULEN_LO   = 39;
   localparam int OFS_PAYLOAD   = 42;
   localparam int UDP_HDR_BYTES = 8;

   localparam logic [7:0] ETYPE_HI_IPV4 = 8'h08;
   localparam logic [7:0] ETYPE_LO_IPV4 = 8'h00;
   localparam logic [7:0] IP_PROTO_UDP  = 8'd17;

   // Signature "SEG{" and the closing brace.
   localparam logic [7:0] SIG_S     = 8'h53;
   localparam logic [7:0] SIG_E     = 8'h45;
   localparam logic [7:0] SIG_G     = 8'h47;
   localparam logic [7:0] SIG_OPEN  = 8'h7B;
   localparam logic [7:0] SIG_CLOSE = 8'h7D;

   // Result kinds.
   typedef enum logic [1:0] {
      KIND_NONE   = 2'd0,
      KIND_BYTE   = 2'd1,
      KIND_COMMIT = 2'd2,
      KIND_ABORT  = 2'd3
   } kind_type;

   // Signature search progress, then capturing, then finished for the frame.
   typedef enum logic [2:0] {
      PH_SEEN0   = 3'd0,
      PH_SEEN1   = 3'd1,
      PH_SEEN2   = 3'd2,
      PH_SEEN3   = 3'd3,
      PH_CAPTURE = 3'd4,
      PH_DONE    = 3'd5
   } phase_type;

   // One step of the "SEG{" matcher. A mismatch restarts the search, and the
   // mismatching byte may itself open a new attempt.
   function automatic phase_type advance_match(input phase_type ph, input logic [7:0] b);
      phase_type restart;
      phase_type nxt;
      restart = (b == SIG_S) ? PH_SEEN1 : PH_SEEN0;
      case (ph)
         PH_SEEN0: nxt = restart;
         PH_SEEN1: nxt = (b == SIG_E)    ? PH_SEEN2   : restart;
         PH_SEEN2: nxt = (b == SIG_G)    ? PH_SEEN3   : restart;
         PH_SEEN3: nxt = (b == SIG_OPEN) ? PH_CAPTURE : restart;
         default:  nxt = restart;
      endcase
      return nxt;
   endfunction

endpackage

`default_nettype wire

// File: rtl/udp_braced_signature_extract.sv
`timescale 1ns / 1ps
`default_nettype none

// Scans raw Ethernet frames, one byte per transaction in wire order, for UDP
// over IPv4 (ethertype 0x0800, protocol 17, fixed 20-byte IP header). It
// counts UDP frames, latches the UDP source port and length, and looks in
// the UDP payload for the first "SEG{" followed by a non-empty run closed by
// '}'. Run bytes leave as tentative bytes (tuser 1); the run then ends with
// a commit on the closing brace (tuser 2) or an abort (tuser 3) when the run
// hits the capture limit or the payload, scan window or frame ends first.
// Every accepted byte yields exactly one result transaction, most with
// tuser 0. A byte is accepted every cycle when the result side keeps up.
// A byte is registered in the input register and its result then in the
// result register, which drives the result channel; a held result keeps
// the following byte waiting in the input register. One byte per cycle is
// sustained when the result side keeps up, since the per-byte frame state
// update is combinational between the two registers.
// The input register doubles as a skid stage, so one more byte is still
// taken while a finished result waits for rsp_tready. Only payload bytes
// below frame offset MAX_FRAME are scanned; only the first capture of a
// frame is taken. The UDP frame and capture counters wrap and survive frame
// ends.

module udp_braced_signature_extract (
   input  wire logic         clock,
   input  wire logic         reset,

   input  wire logic         req_tvalid,
   output      logic         req_tready,
   input  wire logic [7:0]   req_tdata,   // [7:0] frame_byte
   input  wire logic         req_tlast,   // frame_last

   output      logic         rsp_tvalid,
   input  wire logic         rsp_tready,
   output      logic [103:0] rsp_tdata,   // [7:0] capture_byte, [23:8] source_port,
                                          // [34:24] capture_length, [66:35] udp_frames,
                                          // [98:67] captures_found, [103:99] zero
   output      logic [1:0]   rsp_tuser    // [1:0] kind
);

   localparam int PLEN_W = 17;

   // Input register.
   logic                      in_valid_ff;
   logic [7:0]                in_byte_ff;
   logic                      in_last_ff;

   // Per-frame state.
   logic [udpsig_pkg::POS_W-1:0] pos_ff,      pos_in;
   logic                         is_ipv4_ff,  is_ipv4_in;
   logic                         is_udp_ff,   is_udp_in;
   logic [15:0]                  port_ff,     port_in;
   logic [15:0]                  ulen_ff,     ulen_in;
   udpsig_pkg::phase_type        phase_ff,    phase_in;
   logic [udpsig_pkg::CAP_W-1:0] cap_ff,      cap_in;

   // Counters that persist across frames.
   logic [31:0]                  udp_cnt_ff,  udp_cnt_in;
   logic [31:0]                  found_cnt_ff, found_cnt_in;

   // Result register.
   logic                         rsp_valid_ff;
   udpsig_pkg::kind_type         rsp_kind_ff, kind_in;
   logic [98:0]                  rsp_data_ff, rsp_data_in;

   logic                         advance;
   logic [7:0]                   cbyte_in;
   logic [udpsig_pkg::CAP_W-1:0] clen_in;
   logic [PLEN_W-1:0]            pay_end;
   logic [PLEN_W-1:0]            pos_ext;
   logic                         in_payload;
   logic                         final_byte;
   logic                         at_limit;

   // The stored byte moves on whenever the result register is free or draining.
   assign advance    = in_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;

   assign pos_ext = PLEN_W'(pos_ff);
   assign pay_end = PLEN_W'(ulen_ff) +
                    PLEN_W'(udpsig_pkg::OFS_PAYLOAD - udpsig_pkg::UDP_HDR_BYTES);

   // Field latches and per-frame scanning state. The header fields are all
   // before the payload, so the payload test can use the registered values.
   always_comb begin
      pos_in       = pos_ff;
      is_ipv4_in   = is_ipv4_ff;
      is_udp_in    = is_udp_ff;
      port_in      = port_ff;
      ulen_in      = ulen_ff;
      phase_in     = phase_ff;
      cap_in       = cap_ff;
      udp_cnt_in   = udp_cnt_ff;
      found_cnt_in = found_cnt_ff;
      kind_in      = udpsig_pkg::KIND_NONE;
      cbyte_in     = 8'h00;

      if (pos_ff == udpsig_pkg::POS_W'(udpsig_pkg::OFS_ETYPE_HI)) begin
         is_ipv4_in = (in_byte_ff == udpsig_pkg::ETYPE_HI_IPV4);
      end else if (pos_ff == udpsig_pkg::POS_W'(udpsig_pkg::OFS_ETYPE_LO)) begin
         is_ipv4_in = is_ipv4_ff && (in_byte_ff == udpsig_pkg::ETYPE_LO_IPV4);
      end else if (pos_ff == udpsig_pkg::POS_W'(udpsig_pkg::OFS_IP_PROTO)) begin
         is_udp_in = is_ipv4_ff && (in_byte_ff == udpsig_pkg::IP_PROTO_UDP);
         if (is_ipv4_ff && (in_byte_ff == udpsig_pkg::IP_PROTO_UDP)) begin
            udp_cnt_in = udp_cnt_ff + 32'd1;
         end
      end else if (is_udp_ff && pos_ff == udpsig_pkg::POS_W'(udpsig_pkg::OFS_SPORT_HI)) begin
         port_in = {in_byte_ff, 8'h00};
      end else if (is_udp_ff && pos_ff == udpsig_pkg::POS_W'(udpsig_pkg::OFS_SPORT_LO)) begin
         port_in = {port_ff[15:8], in_byte_ff};
      end else if (is_udp_ff && pos_ff == udpsig_pkg::POS_W'(udpsig_pkg::OFS_ULEN_HI)) begin
         ulen_in = {in_byte_ff, 8'h00};
      end else if (is_udp_ff && pos_ff == udpsig_pkg::POS_W'(udpsig_pkg::OFS_ULEN_LO)) begin
         ulen_in = {ulen_ff[15:8], in_byte_ff};
      end

      in_payload = is_udp_ff
                && (pos_ff >= udpsig_pkg::POS_W'(udpsig_pkg::OFS_PAYLOAD))
                && (pos_ff <  udpsig_pkg::POS_W'(udpsig_pkg::MAX_FRAME))
                && (ulen_ff >= 16'(udpsig_pkg::UDP_HDR_BYTES))
                && (pos_ext < pay_end);

      // Last byte that can still be scanned in this frame.
      final_byte = in_last_ff
                || (pos_ext + PLEN_W'(1) == pay_end)
                || (pos_ff == udpsig_pkg::POS_W'(udpsig_pkg::MAX_FRAME - 1));

      at_limit = ({1'b0, cap_ff} + (udpsig_pkg::CAP_W + 1)'(1))
                 >= (udpsig_pkg::CAP_W + 1)'(udpsig_pkg::MAX_CAPTURE_LIMIT);

      if (in_payload) begin
         if (phase_ff == udpsig_pkg::PH_CAPTURE) begin
            if (in_byte_ff == udpsig_pkg::SIG_CLOSE) begin
               if (cap_ff != '0) begin
                  kind_in      = udpsig_pkg::KIND_COMMIT;
                  found_cnt_in = found_cnt_ff + 32'd1;
                  phase_in     = udpsig_pkg::PH_DONE;
               end else begin
                  // An empty run: keep searching from the next byte.
                  phase_in = udpsig_pkg::PH_SEEN0;
               end
            end else if (final_byte) begin
               if (cap_ff != '0) begin
                  kind_in = udpsig_pkg::KIND_ABORT;
               end
               phase_in = udpsig_pkg::PH_DONE;
            end else if (at_limit) begin
               kind_in  = udpsig_pkg::KIND_ABORT;
               phase_in = udpsig_pkg::advance_match(udpsig_pkg::PH_SEEN0, in_byte_ff);
            end else begin
               kind_in  = udpsig_pkg::KIND_BYTE;
               cbyte_in = in_byte_ff;
               cap_in   = cap_ff + udpsig_pkg::CAP_W'(1);
            end
         end else if (phase_ff != udpsig_pkg::PH_DONE) begin
            phase_in = udpsig_pkg::advance_match(phase_ff, in_byte_ff);
            cap_in   = '0;
         end
      end

      // Reported length is the count after this byte; an abort then empties it.
      clen_in = cap_in;
      if (kind_in == udpsig_pkg::KIND_ABORT) begin
         cap_in = '0;
      end

      rsp_data_in = {found_cnt_in, udp_cnt_in, clen_in, port_in, cbyte_in};

      if (in_last_ff) begin
         pos_in     = '0;
         is_ipv4_in = 1'b0;
         is_udp_in  = 1'b0;
         port_in    = '0;
         ulen_in    = '0;
         phase_in   = udpsig_pkg::PH_SEEN0;
         cap_in     = '0;
      end else if (pos_ff < udpsig_pkg::POS_W'(udpsig_pkg::MAX_FRAME)) begin
         pos_in = pos_ff + udpsig_pkg::POS_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         pos_ff       <= '0;
         is_ipv4_ff   <= 1'b0;
         is_udp_ff    <= 1'b0;
         port_ff      <= '0;
         ulen_ff      <= '0;
         phase_ff     <= udpsig_pkg::PH_SEEN0;
         cap_ff       <= '0;
         udp_cnt_ff   <= '0;
         found_cnt_ff <= '0;
      end else begin
         if (req_tvalid && req_tready) begin
            in_valid_ff <= 1'b1;
         end else if (advance) begin
            in_valid_ff <= 1'b0;
         end

         if (advance) begin
            rsp_valid_ff <= 1'b1;
            pos_ff       <= pos_in;
            is_ipv4_ff   <= is_ipv4_in;
            is_udp_ff    <= is_udp_in;
            port_ff      <= port_in;
            ulen_ff      <= ulen_in;
            phase_ff     <= phase_in;
            cap_ff       <= cap_in;
            udp_cnt_ff   <= udp_cnt_in;
            found_cnt_ff <= found_cnt_in;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Payload registers carry no reset.
   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_byte_ff <= req_tdata;
         in_last_ff <= req_tlast;
      end
      if (advance) begin
         rsp_kind_ff <= kind_in;
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_kind_ff;
   assign rsp_tdata  = {5'b00000, rsp_data_ff};

   // A run never grows to the capture limit.
   a_cap_bound: assert property (@(posedge clock) disable iff (reset)
      cap_ff < udpsig_pkg::CAP_W'(udpsig_pkg::MAX_CAPTURE_LIMIT))
      else $error("capture count reached the capture limit");

   // A commit always closes a non-empty run.
   a_commit_len: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_kind_ff == udpsig_pkg::KIND_COMMIT) |-> (rsp_data_ff[34:24] != '0))
      else $error("commit with zero captured length");

   // Each commit bumps the capture counter by exactly one.
   a_commit_count: assert property (@(posedge clock) disable iff (reset)
      (advance && kind_in == udpsig_pkg::KIND_COMMIT)
      |=> (found_cnt_ff == $past(found_cnt_ff) + 32'd1))
      else $error("capture counter did not follow a commit");

   // Capturing only happens inside a UDP frame.
   a_capture_udp: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == udpsig_pkg::PH_CAPTURE) |-> is_udp_ff)
      else $error("capturing outside a UDP frame");

endmodule

`default_nettype wire
